// ----- hdl/bilinear_image_resampler_core_defines.svh -----
// Assertion macros shared by the resampler checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BILINEAR_IMAGE_RESAMPLER_CORE_DEFINES_SVH
`define BILINEAR_IMAGE_RESAMPLER_CORE_DEFINES_SVH

// Same-cycle implication.
`define BIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bir_pkg.sv -----
// Shared widths, codes and reset values of the bilinear resampler.
// No dependencies; used by the interfaces, the core and the checker.
package bir_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_HEIGHT = 2'd0,
    REG_SRC_WIDTH  = 2'd1,
    REG_INV_SCALE  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 9'd256;
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd65536;

endpackage

// ----- hdl/bir_if.sv -----
// Channel interfaces of the resampler: config writes, input beats, result beats.
// Depends on bir_pkg for field widths.
interface bir_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bir_pkg::CFG_IDX_W-1:0]       index;
  logic [bir_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface bir_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [bir_pkg::COORD_W-1:0]         row;
  logic [bir_pkg::COORD_W-1:0]         col;
  logic [bir_pkg::CH_W-1:0]            red_in;
  logic [bir_pkg::CH_W-1:0]            green_in;
  logic [bir_pkg::CH_W-1:0]            blue_in;

  modport source (output valid, kind, row, col, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, kind, row, col, red_in, green_in, blue_in, output ready);
endinterface

interface bir_out_if;
  logic                                valid;
  logic                                ready;
  logic [bir_pkg::CH_W-1:0]            red_out;
  logic [bir_pkg::CH_W-1:0]            green_out;
  logic [bir_pkg::CH_W-1:0]            blue_out;
  logic                                clamped;

  modport source (output valid, red_out, green_out, blue_out, clamped, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, clamped, output ready);
endinterface

// ----- hdl/bilinear_image_resampler_core.sv -----
// Bilinear image resampler: four-bank frame store plus a five-stage query pipeline.
// Depends on bir_pkg and the channel interfaces in bir_if.sv.
//
//   channel | dir | handshake      | beat carries
//   cfg_i   | in  | valid/ready    | index, data (ready is always high)
//   in_i    | in  | valid/ready    | kind, row, col, red_in, green_in, blue_in
//   out_o   | out | valid/ready    | red_out, green_out, blue_out, clamped
//
// One beat per clock while out_o is not backpressured; a query result reaches out_o through
// the map multiply, bank read, column blend and row blend into the output reg.
// The store is split by row and column parity so the four neighbors come out of
// four single-port-read banks in the same cycle. Loads write at the read stage,
// keeping store accesses in beat order. Reset clears control state only; store
// contents stay undefined until loaded. Each stage holds only when the one after
// it is full and stalled, so bubbles collapse under out_o backpressure.
module bilinear_image_resampler_core #(
  parameter int unsigned MAX_ROWS      = 256,
  parameter int unsigned MAX_COLS      = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bir_cfg_if.sink   cfg_i,
  bir_in_if.sink    in_i,
  bir_out_if.source out_o
);

  localparam int unsigned F          = FRACTION_BITS;
  localparam int unsigned RIW        = $clog2(MAX_ROWS);
  localparam int unsigned CIW        = $clog2(MAX_COLS);
  localparam int unsigned RHW        = (RIW > 1) ? RIW - 1 : 1;
  localparam int unsigned CHW        = (CIW > 1) ? CIW - 1 : 1;
  localparam int unsigned BA_W       = RHW + CHW;
  localparam int unsigned BANK_DEPTH = 2 ** BA_W;
  localparam int unsigned POS_W      = bir_pkg::COORD_W + bir_pkg::SCALE_W;
  localparam int unsigned IP_W       = POS_W - F;
  localparam int unsigned WT_W       = F + 1;
  localparam int unsigned HZ_W       = bir_pkg::CH_W + F;
  localparam int unsigned VT_W       = bir_pkg::CH_W + 2 * F;
  localparam int unsigned CH_W       = bir_pkg::CH_W;
  localparam int unsigned PIX_W      = bir_pkg::PIX_W;

  localparam logic [WT_W-1:0] ONE_FIX = {1'b1, {F{1'b0}}};

  // ---------------- configuration ----------------
  logic [bir_pkg::SIZE_W-1:0]  height_q, width_q;
  logic [bir_pkg::SCALE_W-1:0] scale_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= bir_pkg::HEIGHT_RST;
      width_q  <= bir_pkg::WIDTH_RST;
      scale_q  <= bir_pkg::SCALE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bir_pkg::REG_SRC_HEIGHT: height_q <= cfg_i.data[bir_pkg::SIZE_W-1:0];
        bir_pkg::REG_SRC_WIDTH:  width_q  <= cfg_i.data[bir_pkg::SIZE_W-1:0];
        bir_pkg::REG_INV_SCALE:  scale_q  <= cfg_i.data[bir_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // last valid row / column after limiting the size to 1..MAX
  logic [RIW-1:0] row_last;
  logic [CIW-1:0] col_last;

  always_comb begin
    if (height_q == '0) begin
      row_last = '0;
    end else if ({4'd0, height_q} > 13'(MAX_ROWS)) begin
      row_last = RIW'(MAX_ROWS - 1);
    end else begin
      row_last = RIW'(height_q - 1'b1);
    end
  end

  always_comb begin
    if (width_q == '0) begin
      col_last = '0;
    end else if ({4'd0, width_q} > 13'(MAX_COLS)) begin
      col_last = CIW'(MAX_COLS - 1);
    end else begin
      col_last = CIW'(width_q - 1'b1);
    end
  end

  // ---------------- pipeline control ----------------
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q;
  logic en_a, en_b, en_c, en_d, en_e;

  assign en_e = !e_vld_q || out_o.ready;
  assign en_d = !d_vld_q || en_e;
  assign en_c = !c_vld_q || en_d;
  assign en_b = !b_vld_q || en_c;
  assign en_a = !a_vld_q || en_b;

  assign in_i.ready = en_a;

  logic b_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      if (en_a) a_vld_q <= in_i.valid;
      if (en_b) b_vld_q <= a_vld_q;
      // loads retire at the bank stage
      if (en_c) c_vld_q <= b_vld_q && (b_kind_q == bir_pkg::KIND_QUERY);
      if (en_d) d_vld_q <= c_vld_q;
      if (en_e) e_vld_q <= d_vld_q;
    end
  end

  // ---------------- stage A: captured beat ----------------
  logic                       a_kind_q;
  logic [bir_pkg::COORD_W-1:0] a_row_q, a_col_q;
  logic [PIX_W-1:0]           a_pix_q;

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_kind_q <= in_i.kind;
      a_row_q  <= in_i.row;
      a_col_q  <= in_i.col;
      a_pix_q  <= {in_i.red_in, in_i.green_in, in_i.blue_in};
    end
  end

  // ---------------- stage B: mapped positions ----------------
  logic [POS_W-1:0]            b_pos_r_q, b_pos_c_q;
  logic [bir_pkg::COORD_W-1:0] b_row_q, b_col_q;
  logic [PIX_W-1:0]            b_pix_q;
  logic [POS_W-1:0]            pos_r_d, pos_c_d;

  assign pos_r_d = POS_W'(a_row_q) * POS_W'(scale_q);
  assign pos_c_d = POS_W'(a_col_q) * POS_W'(scale_q);

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_kind_q  <= a_kind_q;
      b_pos_r_q <= pos_r_d;
      b_pos_c_q <= pos_c_d;
      b_row_q   <= a_row_q;
      b_col_q   <= a_col_q;
      b_pix_q   <= a_pix_q;
    end
  end

  logic [IP_W-1:0] ip_r, ip_c;
  logic            clip_r, clip_c;
  logic [RIW-1:0]  r0, r1;
  logic [CIW-1:0]  c0, c1;
  logic [F-1:0]    fr_d, fc_d;

  assign ip_r   = b_pos_r_q[POS_W-1:F];
  assign ip_c   = b_pos_c_q[POS_W-1:F];
  assign clip_r = ip_r > IP_W'(row_last);
  assign clip_c = ip_c > IP_W'(col_last);
  assign r0     = clip_r ? row_last : ip_r[RIW-1:0];
  assign c0     = clip_c ? col_last : ip_c[CIW-1:0];
  assign r1     = (r0 < row_last) ? r0 + 1'b1 : row_last;
  assign c1     = (c0 < col_last) ? c0 + 1'b1 : col_last;
  assign fr_d   = clip_r ? '0 : b_pos_r_q[F-1:0];
  assign fc_d   = clip_c ? '0 : b_pos_c_q[F-1:0];

  // load addressing; out-of-store loads are dropped
  logic [RIW-1:0]  ld_row;
  logic [CIW-1:0]  ld_col;
  logic            ld_en;
  logic [BA_W-1:0] waddr;

  assign ld_row = b_row_q[RIW-1:0];
  assign ld_col = b_col_q[CIW-1:0];
  assign ld_en  = b_vld_q && en_c && (b_kind_q == bir_pkg::KIND_LOAD)
               && ({1'b0, b_row_q} < 13'(MAX_ROWS))
               && ({1'b0, b_col_q} < 13'(MAX_COLS));
  assign waddr  = {RHW'(ld_row >> 1), CHW'(ld_col >> 1)};

  // ---------------- frame store banks ----------------
  // bank index = {row parity, column parity}
  logic [PIX_W-1:0] rd_pix [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BANK_ROW = 1'((b >> 1) & 1);
    localparam logic BANK_COL = 1'(b & 1);

    logic [PIX_W-1:0] mem_q [BANK_DEPTH];
    logic [PIX_W-1:0] rd_q;
    logic [RIW-1:0]   rsel;
    logic [CIW-1:0]   csel;
    logic [BA_W-1:0]  raddr;
    logic             we;

    assign rsel  = (r0[0] == BANK_ROW) ? r0 : r1;
    assign csel  = (c0[0] == BANK_COL) ? c0 : c1;
    assign raddr = {RHW'(rsel >> 1), CHW'(csel >> 1)};
    assign we    = ld_en && (ld_row[0] == BANK_ROW) && (ld_col[0] == BANK_COL);

    always_ff @(posedge clk_i) begin
      if (we) mem_q[waddr] <= b_pix_q;
      if (en_c) rd_q <= mem_q[raddr];
    end

    assign rd_pix[b] = rd_q;
  end

  // ---------------- stage C: column blend ----------------
  logic         c_r0p_q, c_r1p_q, c_c0p_q, c_c1p_q, c_clip_q;
  logic [F-1:0] c_fr_q, c_fc_q;

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      c_r0p_q  <= r0[0];
      c_r1p_q  <= r1[0];
      c_c0p_q  <= c0[0];
      c_c1p_q  <= c1[0];
      c_fr_q   <= fr_d;
      c_fc_q   <= fc_d;
      c_clip_q <= clip_r | clip_c;
    end
  end

  logic [PIX_W-1:0] p00, p01, p10, p11;
  logic [WT_W-1:0]  fc_inv;
  logic [HZ_W-1:0]  top_d [3];
  logic [HZ_W-1:0]  bot_d [3];

  assign p00    = rd_pix[{c_r0p_q, c_c0p_q}];
  assign p01    = rd_pix[{c_r0p_q, c_c1p_q}];
  assign p10    = rd_pix[{c_r1p_q, c_c0p_q}];
  assign p11    = rd_pix[{c_r1p_q, c_c1p_q}];
  assign fc_inv = ONE_FIX - WT_W'(c_fc_q);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      top_d[ch] = HZ_W'(p00[PIX_W-1-CH_W*ch -: CH_W]) * HZ_W'(fc_inv)
                + HZ_W'(p01[PIX_W-1-CH_W*ch -: CH_W]) * HZ_W'(c_fc_q);
      bot_d[ch] = HZ_W'(p10[PIX_W-1-CH_W*ch -: CH_W]) * HZ_W'(fc_inv)
                + HZ_W'(p11[PIX_W-1-CH_W*ch -: CH_W]) * HZ_W'(c_fc_q);
    end
  end

  // ---------------- stage D: row blend ----------------
  logic [HZ_W-1:0] d_top_q [3];
  logic [HZ_W-1:0] d_bot_q [3];
  logic [F-1:0]    d_fr_q;
  logic            d_clip_q;

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      d_top_q  <= top_d;
      d_bot_q  <= bot_d;
      d_fr_q   <= c_fr_q;
      d_clip_q <= c_clip_q;
    end
  end

  logic [WT_W-1:0] fr_inv;
  logic [VT_W-1:0] sum_d [3];

  assign fr_inv = ONE_FIX - WT_W'(d_fr_q);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = VT_W'(d_top_q[ch]) * VT_W'(fr_inv)
                + VT_W'(d_bot_q[ch]) * VT_W'(d_fr_q);
    end
  end

  // ---------------- stage E: output register ----------------
  logic [CH_W-1:0] e_red_q, e_green_q, e_blue_q;
  logic            e_clip_q;

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      e_red_q   <= sum_d[0][VT_W-1:2*F];
      e_green_q <= sum_d[1][VT_W-1:2*F];
      e_blue_q  <= sum_d[2][VT_W-1:2*F];
      e_clip_q  <= d_clip_q;
    end
  end

  assign out_o.valid     = e_vld_q;
  assign out_o.red_out   = e_red_q;
  assign out_o.green_out = e_green_q;
  assign out_o.blue_out  = e_blue_q;
  assign out_o.clamped   = e_clip_q;

endmodule

// ----- hdl/bir_checker.sv -----
// Port-level checker for the resampler core, attached by bind below.
// Depends on bir_pkg and the macros in bilinear_image_resampler_core_defines.svh.
`include "bilinear_image_resampler_core_defines.svh"

module bir_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     in_kind_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [bir_pkg::CH_W-1:0] out_red_i,
  input logic [bir_pkg::CH_W-1:0] out_green_i,
  input logic [bir_pkg::CH_W-1:0] out_blue_i,
  input logic                     out_clamped_i
);

  // queries taken but whose result beat has not gone out yet
  logic [3:0] pending_q, pending_d;
  logic       q_acc, o_acc;

  assign q_acc     = in_valid_i && in_ready_i && (in_kind_i == bir_pkg::KIND_QUERY);
  assign o_acc     = out_valid_i && out_ready_i;
  assign pending_d = pending_q + 4'(q_acc) - 4'(o_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `BIR_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_red_i) && $stable(out_green_i) && $stable(out_blue_i) && $stable(out_clamped_i), "result beat changed while stalled")
  `BIR_ASSERT_IMP(a_no_orphan, out_valid_i, pending_q != 4'd0, "result beat without a pending query")
  `BIR_ASSERT_IMP(a_depth_cap, 1'b1, pending_q <= 4'd5, "more queries in flight than pipeline stages")
  `BIR_ASSERT_IMP(a_idle_ready, pending_q == 4'd0, in_ready_i, "input stalled with no query in flight")

endmodule

bind bilinear_image_resampler_core bir_checker u_bir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_red_i     (out_o.red_out),
  .out_green_i   (out_o.green_out),
  .out_blue_i    (out_o.blue_out),
  .out_clamped_i (out_o.clamped)
);

// ----- tb/bilinear_image_resampler_core_test.sv -----
// Self-checking bench for bilinear_image_resampler_core: load and query beats, per-field checks.
// Depends on bir_pkg and the channel interfaces in bir_if.sv; predicts results on its own.
module bilinear_image_resampler_core_test;

  localparam int unsigned COORD_W      = bir_pkg::COORD_W;
  localparam int unsigned CH_W         = bir_pkg::CH_W;
  localparam int unsigned PIX_W        = bir_pkg::PIX_W;
  localparam int unsigned SIZE_W       = bir_pkg::SIZE_W;
  localparam int unsigned SCALE_W      = bir_pkg::SCALE_W;
  localparam int unsigned CFG_DATA_W   = bir_pkg::CFG_DATA_W;
  localparam int unsigned ROWS         = 256;
  localparam int unsigned COLS         = 256;
  localparam int unsigned FRAC_W       = 16;
  localparam longint unsigned ONE      = 64'd1 << FRAC_W;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PHASES       = 15;
  localparam int unsigned PHASE_ITEMS  = 110;

  typedef struct packed {
    bir_pkg::kind_e     kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
  } pixel_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            clamped;
  } rgb_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bir_cfg_if cfg_bus ();
  bir_in_if  pix_in ();
  bir_out_if pix_out ();

  bilinear_image_resampler_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (pix_in),
    .out_o  (pix_out)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block: frame contents and register values as the block holds them
  logic [PIX_W-1:0]   src_frame [ROWS*COLS];
  logic [SIZE_W-1:0]  height_reg = bir_pkg::HEIGHT_RST;
  logic [SIZE_W-1:0]  width_reg  = bir_pkg::WIDTH_RST;
  logic [SCALE_W-1:0] scale_reg  = bir_pkg::SCALE_RST;

  // Pixels some queued beat already loads, so no query ever reads an unwritten one
  bit loaded_mask [ROWS*COLS];

  pixel_beat_t pending_beats [$];
  rgb_result_t expected_pixels [$];
  pixel_beat_t held_beat;
  bit          beat_held = 1'b0;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 69;
  int unsigned fail_count    = 0;

  function automatic int unsigned clip_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // One axis: top-left index, neighbor clamped to the edge, fraction; returns the clamp flag
  function automatic bit map_axis(input logic [COORD_W-1:0] coord, input int unsigned size,
                                  output int unsigned lo, output int unsigned hi,
                                  output longint unsigned frac);
    longint unsigned pos;
    longint unsigned ip;
    bit              clip;
    pos  = 64'(coord) * 64'(scale_reg);
    ip   = pos >> FRAC_W;
    frac = pos & (ONE - 1);
    clip = 1'b0;
    if (ip > size - 1) begin
      ip   = 64'(size - 1);
      frac = 0;
      clip = 1'b1;
    end
    lo = 32'(ip);
    hi = (lo + 1 < size) ? lo + 1 : size - 1;
    return clip;
  endfunction

  function automatic rgb_result_t resample_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    int unsigned     r0, r1, c0, c1;
    longint unsigned fr, fc, sum;
    longint unsigned wt [4];
    logic [PIX_W-1:0] px [4];
    logic [CH_W-1:0]  chan [3];
    rgb_result_t      res;
    res.clamped = map_axis(row, clip_size(height_reg, ROWS), r0, r1, fr);
    res.clamped |= map_axis(col, clip_size(width_reg, COLS), c0, c1, fc);
    px[0] = src_frame[r0*COLS + c0];
    px[1] = src_frame[r0*COLS + c1];
    px[2] = src_frame[r1*COLS + c0];
    px[3] = src_frame[r1*COLS + c1];
    wt[0] = (ONE - fr) * (ONE - fc);
    wt[1] = (ONE - fr) * fc;
    wt[2] = fr * (ONE - fc);
    wt[3] = fr * fc;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int k = 0; k < 4; k++) sum += 64'(px[k][16-8*ch +: 8]) * wt[k];
      chan[ch] = sum[2*FRAC_W +: CH_W];
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  function automatic void take_beat(pixel_beat_t b);
    if (b.kind == bir_pkg::KIND_LOAD) begin
      if (b.row < ROWS && b.col < COLS) src_frame[b.row*COLS + b.col] = {b.red, b.green, b.blue};
    end else begin
      expected_pixels.push_back(resample_pixel(b.row, b.col));
    end
  endfunction

  function automatic void compare_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_pixel(rgb_result_t got);
    rgb_result_t want;
    if (expected_pixels.size() == 0) begin
      $error("result beat with no query outstanding");
      fail_count++;
      return;
    end
    want = expected_pixels.pop_front();
    compare_field("red_out", want.red, got.red);
    compare_field("green_out", want.green, got.green);
    compare_field("blue_out", want.blue, got.blue);
    compare_field("clamped", CH_W'(want.clamped), CH_W'(got.clamped));
  endfunction

  function automatic void plan_load(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                    logic [PIX_W-1:0] rgb);
    pixel_beat_t b;
    b.kind = bir_pkg::KIND_LOAD;
    b.row  = row;
    b.col  = col;
    {b.red, b.green, b.blue} = rgb;
    if (row < ROWS && col < COLS) loaded_mask[row*COLS + col] = 1'b1;
    pending_beats.push_back(b);
  endfunction

  // Loads any missing neighbor with random content first, then queues the query
  function automatic void plan_query(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    int unsigned     nr [2];
    int unsigned     nc [2];
    longint unsigned frac;
    pixel_beat_t     b;
    void'(map_axis(row, clip_size(height_reg, ROWS), nr[0], nr[1], frac));
    void'(map_axis(col, clip_size(width_reg, COLS), nc[0], nc[1], frac));
    foreach (nr[i])
      foreach (nc[j])
        if (!loaded_mask[nr[i]*COLS + nc[j]])
          plan_load(COORD_W'(nr[i]), COORD_W'(nc[j]), PIX_W'($urandom));
    b.kind = bir_pkg::KIND_QUERY;
    b.row  = row;
    b.col  = col;
    {b.red, b.green, b.blue} = PIX_W'($urandom);
    pending_beats.push_back(b);
  endfunction

  // Mostly coordinates that land inside the source, some anywhere in the 12-bit range
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned size);
    longint unsigned span;
    if (scale_reg == 0 || $urandom_range(9) < 3) return COORD_W'($urandom);
    span = (64'(size) << FRAC_W) / scale_reg + 2;
    if (span > 4095) span = 4095;
    return COORD_W'($urandom_range(32'(span)));
  endfunction

  // Queues about n beats, neighbor loads of queries included
  function automatic void plan_random(int unsigned n);
    int unsigned h, w, pick, goal;
    h    = clip_size(height_reg, ROWS);
    w    = clip_size(width_reg, COLS);
    goal = 32'(pending_beats.size()) + n;
    while (32'(pending_beats.size()) < goal) begin
      pick = $urandom_range(99);
      if (pick < 58) plan_query(pick_coord(h), pick_coord(w));
      else if (pick < 88)
        plan_load(COORD_W'($urandom_range(h - 1)), COORD_W'($urandom_range(w - 1)),
                  PIX_W'($urandom));
      else if (pick < 94)
        plan_load(COORD_W'($urandom_range(ROWS - 1)), COORD_W'($urandom_range(COLS - 1)),
                  PIX_W'($urandom));
      else plan_load(COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
    end
  endfunction

  task automatic write_reg(bir_pkg::cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      bir_pkg::REG_SRC_HEIGHT: height_reg = val[SIZE_W-1:0];
      bir_pkg::REG_SRC_WIDTH:  width_reg  = val[SIZE_W-1:0];
      bir_pkg::REG_INV_SCALE:  scale_reg  = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Sender holds off until every query has answered, then lets loads settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || beat_held || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_in.valid && pix_in.ready) begin
        take_beat(held_beat);
        beat_held = 1'b0;
      end
      if (!beat_held && pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        held_beat = pending_beats.pop_front();
        beat_held = 1'b1;
        pix_in.kind     <= held_beat.kind;
        pix_in.row      <= held_beat.row;
        pix_in.col      <= held_beat.col;
        pix_in.red_in   <= held_beat.red;
        pix_in.green_in <= held_beat.green;
        pix_in.blue_in  <= held_beat.blue;
      end
      pix_in.valid <= beat_held;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_out.valid && pix_out.ready)
        check_pixel({pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.clamped});
      pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [SIZE_W-1:0]  h, w;
    logic [SCALE_W-1:0] s;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = bir_pkg::REG_SRC_HEIGHT;
    cfg_bus.data     = '0;
    pix_in.valid     = 1'b0;
    pix_in.kind      = bir_pkg::KIND_LOAD;
    pix_in.row       = '0;
    pix_in.col       = '0;
    pix_in.red_in    = '0;
    pix_in.green_in  = '0;
    pix_in.blue_in   = '0;
    pix_out.ready    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, unit scale: exact pixels, bottom-right corner, clamping, stray loads
    plan_load(0, 0, 24'hFFFFFF);
    plan_load(0, 1, 24'h000000);
    plan_load(1, 0, 24'h8001FE);
    plan_load(1, 1, 24'h7FAA55);
    plan_query(0, 0);
    plan_query(1, 1);
    plan_load(255, 255, 24'h000000);
    plan_query(255, 255);
    plan_query(256, 0);
    plan_query(12'hFFF, 12'hFFF);
    plan_load(12'hFFF, 0, 24'h123456);
    plan_load(0, 256, 24'hABCDEF);
    plan_load(256, 256, 24'h00FF00);
    plan_query(0, 0);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 5) begin
        send_idle_pct = 69;
        recv_idle_pct = 35;
      end else if (ph == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin h = 9'd256; w = 9'd256; s = 24'h008000; end
        1: begin h = 9'd4;   w = 9'd4;   s = 24'h010000; end
        2: begin h = 9'd0;   w = 9'd0;   s = 24'h000000; end
        3: begin h = 9'd511; w = 9'd7;   s = 24'h000001; end
        4: begin h = 9'd256; w = 9'd256; s = 24'hFFFFFF; end
        5: begin h = 9'd1;   w = 9'd256; s = 24'h00C000; end
        6: begin h = 9'd256; w = 9'd1;   s = 24'h018000; end
        7: begin h = 9'd300; w = 9'd257; s = 24'h002000; end
        default: begin
          h = SIZE_W'($urandom_range(1, 24));
          w = SIZE_W'($urandom_range(1, 24));
          s = ($urandom_range(3) == 0) ? SCALE_W'($urandom)
                                       : SCALE_W'($urandom_range(32'h4000, 32'h28000));
        end
      endcase
      write_reg(bir_pkg::REG_SRC_HEIGHT, CFG_DATA_W'(h));
      write_reg(bir_pkg::REG_SRC_WIDTH, CFG_DATA_W'(w));
      write_reg(bir_pkg::REG_INV_SCALE, s);
      if (ph == 0) begin
        // half scale: mid-pixel blends, half past the last row, row and column past the edge
        plan_query(1, 1);
        plan_query(3, 0);
        plan_query(511, 511);
        plan_query(512, 0);
        plan_query(1, 512);
      end
      plan_random(PHASE_ITEMS);
      wait_drained();
    end

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #(20 * 400_000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bir_pkg.sv
hdl/bir_if.sv
hdl/bilinear_image_resampler_core.sv
hdl/bir_checker.sv
tb/bilinear_image_resampler_core_test.sv
